FILE: src/reb_pkg.sv
// Package: shared types, codes and constants of the rotary encoder event block.
package reb_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int MAX_EVENTS         = 10;
    localparam int EV_CNT_W           = 4;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_W        = 2;

    localparam logic [3:0]  DEBOUNCE_RST = 4'd2;
    localparam logic [2:0]  STEPS_RST    = 3'd2;
    localparam logic [15:0] LONG_RST     = 16'd500;
    localparam logic [15:0] REPEAT_RST   = 16'd200;
    localparam logic [15:0] GRACE_RST    = 16'd80;
    localparam logic [15:0] GUARD_RST    = 16'd150;
    localparam logic [15:0] DECAY_RST    = 16'd200;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_STEPS    = 3'd1,
        REG_LONG     = 3'd2,
        REG_REPEAT   = 3'd3,
        REG_GRACE    = 3'd4,
        REG_GUARD    = 3'd5,
        REG_DECAY    = 3'd6,
        REG_NONE     = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        KEY_UP    = 3'd0,
        KEY_DOWN  = 3'd1,
        KEY_LEFT  = 3'd2,
        KEY_RIGHT = 3'd3,
        KEY_OK    = 3'd4,
        KEY_BACK  = 3'd5
    } key_t;

    typedef enum logic [2:0] {
        KIND_PRESS   = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_SHORT   = 3'd2,
        KIND_LONG    = 3'd3,
        KIND_REPEAT  = 3'd4
    } kind_t;

    typedef struct packed {
        logic        enc_a;
        logic        enc_b;
        logic        knob_level;
        logic        side_level;
        logic [31:0] now_tick;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_key;
        logic [2:0]  event_kind;
        logic [31:0] event_seq;
        logic        last_event;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  debounce_count;
        logic [2:0]  steps_per_detent;
        logic [15:0] long_press_time;
        logic [15:0] repeat_time;
        logic [15:0] modifier_grace_time;
        logic [15:0] rotation_guard_time;
        logic [15:0] accum_decay_time;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  event_key;
        logic [2:0]  event_kind;
        logic [31:0] event_seq;
    } event_t;

    // One classified poll: up to ten events and how many are present.
    typedef struct packed {
        event_t [MAX_EVENTS-1:0] ev;
        logic [EV_CNT_W-1:0]     count;
    } batch_t;

    // Quadrature delta: 0 none, 1 plus, 3 minus (2-bit two's complement).
    function automatic logic [1:0] quad_delta(input logic [3:0] idx);
        logic [1:0] d;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = 2'b11;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'b01;
            default:                  d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

FILE: src/reb_front.sv
// Front part: decode, debounce and classify one poll into a batch of events.
module reb_front #(
    parameter int TIME_WIDTH = reb_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  reb_pkg::cfg_t     cfg,
    input  logic              item_valid,
    input  reb_pkg::in_item_t item,
    output logic              item_ready,
    output logic              batch_valid,
    output reb_pkg::batch_t   batch,
    input  logic              batch_ready
);

    logic [1:0]            ab_prev_reg, ab_prev_next;
    logic signed [3:0]     accum_reg, accum_next;
    logic [TIME_WIDTH-1:0] last_step_reg, last_step_next;
    logic [TIME_WIDTH-1:0] last_det_reg, last_det_next;
    logic                  k_raw_reg, k_raw_next, k_stab_reg, k_stab_next;
    logic [3:0]            k_cnt_reg, k_cnt_next;
    logic [TIME_WIDTH-1:0] k_press_reg, k_press_next;
    logic                  k_long_reg, k_long_next, k_rot_reg, k_rot_next;
    logic                  k_guard_reg, k_guard_next;
    logic                  s_raw_reg, s_raw_next, s_stab_reg, s_stab_next;
    logic [3:0]            s_cnt_reg, s_cnt_next;
    logic [TIME_WIDTH-1:0] s_press_reg, s_press_next, s_rep_reg, s_rep_next;
    logic                  s_long_reg, s_long_next;
    logic [31:0]           seq_reg, seq_next;
    logic                  bv_reg, bv_next;
    reb_pkg::batch_t       batch_reg, batch_next;
    logic                  take;

    assign item_ready  = !bv_reg || batch_ready;
    assign take        = item_valid && item_ready;
    assign batch_valid = bv_reg;
    assign batch       = batch_reg;

    always_comb
    begin
        logic [TIME_WIDTH-1:0] now;
        logic [1:0]            ab, d;
        logic signed [3:0]     acc, spd;
        logic                  kp, sp, settled, cw, det;
        logic [1:0]            mode;
        logic [reb_pkg::EV_CNT_W-1:0] n;
        reb_pkg::event_t [reb_pkg::MAX_EVENTS-1:0] ev;

        ab_prev_next = ab_prev_reg; accum_next = accum_reg;
        last_step_next = last_step_reg; last_det_next = last_det_reg;
        k_raw_next = k_raw_reg; k_stab_next = k_stab_reg; k_cnt_next = k_cnt_reg;
        k_press_next = k_press_reg; k_long_next = k_long_reg;
        k_rot_next = k_rot_reg; k_guard_next = k_guard_reg;
        s_raw_next = s_raw_reg; s_stab_next = s_stab_reg; s_cnt_next = s_cnt_reg;
        s_press_next = s_press_reg; s_rep_next = s_rep_reg;
        s_long_next = s_long_reg;
        seq_next = seq_reg;
        bv_next = bv_reg && !batch_ready;
        batch_next = batch_reg;
        ev = '0;
        n = '0;
        d = 2'b00;
        det = 1'b0;
        cw = 1'b0;
        mode = 2'd0;

        now = item.now_tick[TIME_WIDTH-1:0];
        ab  = {item.enc_a, item.enc_b};
        kp  = !item.knob_level;
        sp  = !item.side_level;
        spd = $signed({1'b0, cfg.steps_per_detent});

        // Encoder: drop stale quarter-steps, then accumulate.
        acc = accum_reg;
        if (acc != 4'sd0 && (now - last_step_reg) >= TIME_WIDTH'(cfg.accum_decay_time))
            acc = 4'sd0;
        if (ab != ab_prev_reg) begin
            d = reb_pkg::quad_delta({ab_prev_reg, ab});
            ab_prev_next = ab;
            if (d != 2'b00) begin
                acc = acc + {{2{d[1]}}, d};
                last_step_next = now;
                if (acc >= spd) begin
                    acc = 4'sd0; det = 1'b1; cw = 1'b1;
                end else if (acc <= -spd) begin
                    acc = 4'sd0; det = 1'b1; cw = 1'b0;
                end
            end
        end
        accum_next = acc;

        if (det) begin
            // mode 0 scroll, 1 modifier, 2 jostle
            if (!k_raw_reg && !k_stab_reg)       mode = 2'd0;
            else if (k_long_reg)                 mode = 2'd0;
            else if (k_raw_reg != k_stab_reg)    mode = 2'd2;
            else if ((now - k_press_reg) < TIME_WIDTH'(cfg.modifier_grace_time))
                mode = 2'd2;
            else                                 mode = 2'd1;
            if (mode != 2'd2) last_det_next = now;
            if (mode == 2'd1) begin
                seq_next = seq_next + 32'd1;
                ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_PRESS, seq_next}; n = n + 1'b1;
                seq_next = seq_next + 32'd1;
                ev[n] = {cw ? reb_pkg::KEY_RIGHT : reb_pkg::KEY_LEFT,
                         reb_pkg::KIND_PRESS, seq_next}; n = n + 1'b1;
                ev[n] = {cw ? reb_pkg::KEY_RIGHT : reb_pkg::KEY_LEFT,
                         reb_pkg::KIND_SHORT, seq_next}; n = n + 1'b1;
                ev[n] = {cw ? reb_pkg::KEY_RIGHT : reb_pkg::KEY_LEFT,
                         reb_pkg::KIND_RELEASE, seq_next}; n = n + 1'b1;
                k_rot_next = 1'b1;
            end else if (mode == 2'd0) begin
                seq_next = seq_next + 32'd1;
                ev[n] = {cw ? reb_pkg::KEY_DOWN : reb_pkg::KEY_UP,
                         reb_pkg::KIND_PRESS, seq_next}; n = n + 1'b1;
                ev[n] = {cw ? reb_pkg::KEY_DOWN : reb_pkg::KEY_UP,
                         reb_pkg::KIND_SHORT, seq_next}; n = n + 1'b1;
                ev[n] = {cw ? reb_pkg::KEY_DOWN : reb_pkg::KEY_UP,
                         reb_pkg::KIND_RELEASE, seq_next}; n = n + 1'b1;
            end
        end

        // Knob button debounce.
        if (kp == k_raw_reg) begin
            if (k_cnt_reg < cfg.debounce_count) k_cnt_next = k_cnt_reg + 4'd1;
        end else begin
            k_raw_next = kp; k_cnt_next = 4'd1;
        end
        settled = k_cnt_next >= cfg.debounce_count;
        if (settled) begin
            if (k_stab_reg == k_raw_next) begin
                if (k_stab_reg && !k_long_reg &&
                    (now - k_press_reg) >= TIME_WIDTH'(cfg.long_press_time)) begin
                    k_long_next = 1'b1;
                    seq_next = seq_next + 32'd1;
                    ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_PRESS, seq_next}; n = n + 1'b1;
                    ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_LONG, seq_next}; n = n + 1'b1;
                end
            end else begin
                k_stab_next = k_raw_next;
                if (k_raw_next) begin
                    k_guard_next = (now - last_det_next) <
                                   TIME_WIDTH'(cfg.rotation_guard_time);
                    k_press_next = now;
                    k_rot_next   = 1'b0;
                    k_long_next  = 1'b0;
                end else begin
                    if (k_long_reg || k_rot_next) begin
                        seq_next = seq_next + 32'd1;
                        ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_RELEASE, seq_next};
                        n = n + 1'b1;
                    end else if (!k_guard_reg) begin
                        seq_next = seq_next + 32'd1;
                        ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_PRESS, seq_next};
                        n = n + 1'b1;
                        ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_SHORT, seq_next};
                        n = n + 1'b1;
                        ev[n] = {reb_pkg::KEY_OK, reb_pkg::KIND_RELEASE, seq_next};
                        n = n + 1'b1;
                    end
                    k_rot_next   = 1'b0;
                    k_guard_next = 1'b0;
                end
            end
        end

        // Side key debounce.
        if (sp == s_raw_reg) begin
            if (s_cnt_reg < cfg.debounce_count) s_cnt_next = s_cnt_reg + 4'd1;
        end else begin
            s_raw_next = sp; s_cnt_next = 4'd1;
        end
        settled = s_cnt_next >= cfg.debounce_count;
        if (settled) begin
            if (s_stab_reg == s_raw_next) begin
                if (s_stab_reg) begin
                    if (!s_long_reg && (now - s_press_reg) >=
                        TIME_WIDTH'(cfg.long_press_time)) begin
                        s_long_next = 1'b1;
                        s_rep_next = now;
                        seq_next = seq_next + 32'd1;
                        ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_PRESS, seq_next};
                        n = n + 1'b1;
                        ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_LONG, seq_next};
                        n = n + 1'b1;
                    end else if (s_long_reg && (now - s_rep_reg) >=
                                 TIME_WIDTH'(cfg.repeat_time)) begin
                        s_rep_next = now;
                        ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_REPEAT, seq_next};
                        n = n + 1'b1;
                    end
                end
            end else begin
                s_stab_next = s_raw_next;
                if (s_raw_next) begin
                    s_press_next = now;
                    s_long_next = 1'b0;
                end else if (!s_long_reg) begin
                    seq_next = seq_next + 32'd1;
                    ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_PRESS, seq_next};
                    n = n + 1'b1;
                    ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_SHORT, seq_next};
                    n = n + 1'b1;
                    ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_RELEASE, seq_next};
                    n = n + 1'b1;
                end else begin
                    ev[n] = {reb_pkg::KEY_BACK, reb_pkg::KIND_RELEASE, seq_next};
                    n = n + 1'b1;
                end
            end
        end

        if (take) begin
            bv_next = n != '0;
            batch_next.ev = ev;
            batch_next.count = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ab_prev_reg <= 2'b11; accum_reg <= '0; last_step_reg <= '0;
            last_det_reg <= '0; k_raw_reg <= 1'b0; k_stab_reg <= 1'b0;
            k_cnt_reg <= reb_pkg::DEBOUNCE_RST; k_press_reg <= '0;
            k_long_reg <= 1'b0; k_rot_reg <= 1'b0; k_guard_reg <= 1'b0;
            s_raw_reg <= 1'b0; s_stab_reg <= 1'b0;
            s_cnt_reg <= reb_pkg::DEBOUNCE_RST; s_press_reg <= '0;
            s_long_reg <= 1'b0; s_rep_reg <= '0; seq_reg <= '0; bv_reg <= 1'b0;
        end else begin
            bv_reg <= bv_next;
            if (take) begin
                ab_prev_reg <= ab_prev_next; accum_reg <= accum_next;
                last_step_reg <= last_step_next; last_det_reg <= last_det_next;
                k_raw_reg <= k_raw_next; k_stab_reg <= k_stab_next;
                k_cnt_reg <= k_cnt_next; k_press_reg <= k_press_next;
                k_long_reg <= k_long_next; k_rot_reg <= k_rot_next;
                k_guard_reg <= k_guard_next; s_raw_reg <= s_raw_next;
                s_stab_reg <= s_stab_next; s_cnt_reg <= s_cnt_next;
                s_press_reg <= s_press_next; s_long_reg <= s_long_next;
                s_rep_reg <= s_rep_next; seq_reg <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
    end

endmodule

FILE: src/reb_back.sv
// Back part: queue of batches, drained one event per transfer.
module reb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               batch_valid,
    input  reb_pkg::batch_t    batch,
    output logic               batch_ready,
    output logic               out_valid,
    output reb_pkg::out_item_t out_item,
    input  logic               out_ready
);

    reb_pkg::batch_t mem [reb_pkg::QUEUE_DEPTH];
    logic [reb_pkg::QUEUE_PTR_W-1:0] wr_reg, rd_reg;
    logic [reb_pkg::QUEUE_PTR_W:0]   fill_reg;
    logic [reb_pkg::EV_CNT_W-1:0]    idx_reg;
    reb_pkg::batch_t                 head;
    logic                            push, pop_ev, pop_batch;

    assign head        = mem[rd_reg];
    assign batch_ready = fill_reg != (reb_pkg::QUEUE_PTR_W+1)'(reb_pkg::QUEUE_DEPTH);
    assign push        = batch_valid && batch_ready;
    assign out_valid   = fill_reg != '0;
    assign pop_ev      = out_valid && out_ready;
    assign pop_batch   = pop_ev && (idx_reg + 1'b1 == head.count);
    assign out_item    = {head.ev[idx_reg], idx_reg + 1'b1 == head.count};

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= batch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0; rd_reg <= '0; fill_reg <= '0; idx_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop_batch) begin
                rd_reg  <= rd_reg + 1'b1;
                idx_reg <= '0;
            end else if (pop_ev) begin
                idx_reg <= idx_reg + 1'b1;
            end
            fill_reg <= fill_reg + (push ? 1'b1 : 1'b0) - (pop_batch ? 1'b1 : 1'b0);
        end
    end

endmodule

FILE: src/rotary_encoder_button_events_core.sv
// Top level: configuration registers, front classifier and back event queue.
// An accepted poll's events are registered in the front, then queued for output.
// Throughput: one poll per cycle while the queue has room; events drain one
// per cycle while out_ready is high, so a poll of n events takes n transfers.
// The four-entry batch queue sets how far the front runs ahead of the back.
// Reset (rst_n low, asynchronous): idle pins, empty queue, registers at default.
module rotary_encoder_button_events_core #(
    parameter int TIME_WIDTH = reb_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  reb_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output reb_pkg::out_item_t out_item
);

    reb_pkg::cfg_t    cfg_reg;
    reb_pkg::reg_idx_t ridx;
    logic             bvalid, bready;
    reb_pkg::batch_t  bdata;

    assign pready = 1'b1;

    // Decode register index from the word address.
    always_comb
    begin
        ridx = (paddr[4:2] == 3'd7) ? reb_pkg::REG_NONE : reb_pkg::reg_idx_t'(paddr[4:2]);
    end

    always_comb
    begin
        unique case (ridx)
            reb_pkg::REG_DEBOUNCE: prdata = {28'd0, cfg_reg.debounce_count};
            reb_pkg::REG_STEPS:    prdata = {29'd0, cfg_reg.steps_per_detent};
            reb_pkg::REG_LONG:     prdata = {16'd0, cfg_reg.long_press_time};
            reb_pkg::REG_REPEAT:   prdata = {16'd0, cfg_reg.repeat_time};
            reb_pkg::REG_GRACE:    prdata = {16'd0, cfg_reg.modifier_grace_time};
            reb_pkg::REG_GUARD:    prdata = {16'd0, cfg_reg.rotation_guard_time};
            reb_pkg::REG_DECAY:    prdata = {16'd0, cfg_reg.accum_decay_time};
            default:               prdata = 32'd0;
        endcase
    end

    // Write the addressed register on the access-phase transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= {reb_pkg::DEBOUNCE_RST, reb_pkg::STEPS_RST, reb_pkg::LONG_RST,
                        reb_pkg::REPEAT_RST, reb_pkg::GRACE_RST, reb_pkg::GUARD_RST,
                        reb_pkg::DECAY_RST};
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                reb_pkg::REG_DEBOUNCE: cfg_reg.debounce_count      <= pwdata[3:0];
                reb_pkg::REG_STEPS:    cfg_reg.steps_per_detent    <= pwdata[2:0];
                reb_pkg::REG_LONG:     cfg_reg.long_press_time     <= pwdata[15:0];
                reb_pkg::REG_REPEAT:   cfg_reg.repeat_time         <= pwdata[15:0];
                reb_pkg::REG_GRACE:    cfg_reg.modifier_grace_time <= pwdata[15:0];
                reb_pkg::REG_GUARD:    cfg_reg.rotation_guard_time <= pwdata[15:0];
                reb_pkg::REG_DECAY:    cfg_reg.accum_decay_time    <= pwdata[15:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: classify each poll into a batch of events.
    reb_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (in_valid),
        .item        (in_item),
        .item_ready  (in_ready),
        .batch_valid (bvalid),
        .batch       (bdata),
        .batch_ready (bready)
    );

    // Back: hold batches and drain one event per transfer.
    reb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (bvalid),
        .batch       (bdata),
        .batch_ready (bready),
        .out_valid   (out_valid),
        .out_item    (out_item),
        .out_ready   (out_ready)
    );

endmodule
